### design/ata_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ata_pkg: shared types and constants for the tilt angle unit
// Holds the payload structs, register indexes and the arctangent table.
// ----------------------------------------------------------------------------
package ata_pkg;

  localparam int ANGLE_FRAC_BITS_DEF = 8;
  localparam int UNIT_BITS           = 20;
  localparam int CORDIC_STEPS        = 24;
  localparam int SQRT_STEPS          = 31;
  localparam int FIFO_DEPTH          = 4;

  localparam logic [1:0] REG_OFFSET_X = 2'd0;
  localparam logic [1:0] REG_OFFSET_Y = 2'd1;
  localparam logic [1:0] REG_OFFSET_Z = 2'd2;
  localparam logic [1:0] REG_GRAVITY  = 2'd3;
  localparam logic [14:0] GRAVITY_RESET = 15'd8192;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] corr_x;
    logic signed [15:0] corr_y;
    logic signed [15:0] corr_z;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
  } out_item_t;

  // Corrected axes handed from the front end to the angle pipeline.
  typedef struct packed {
    logic signed [15:0] cx;
    logic signed [15:0] cy;
    logic signed [15:0] cz;
  } corr_t;

  // atan(2^-i) in units of 2^-20 degree
  function automatic logic [25:0] atan_tab(input logic [4:0] i);
    logic [25:0] v;
    begin
      v = '0;
      unique case (i)
        5'd0:  v = 26'd47185920;
        5'd1:  v = 26'd27855475;
        5'd2:  v = 26'd14718068;
        5'd3:  v = 26'd7471121;
        5'd4:  v = 26'd3750058;
        5'd5:  v = 26'd1876857;
        5'd6:  v = 26'd938658;
        5'd7:  v = 26'd469357;
        5'd8:  v = 26'd234682;
        5'd9:  v = 26'd117342;
        5'd10: v = 26'd58671;
        5'd11: v = 26'd29335;
        5'd12: v = 26'd14668;
        5'd13: v = 26'd7334;
        5'd14: v = 26'd3667;
        5'd15: v = 26'd1833;
        5'd16: v = 26'd917;
        5'd17: v = 26'd458;
        5'd18: v = 26'd229;
        5'd19: v = 26'd115;
        5'd20: v = 26'd57;
        5'd21: v = 26'd29;
        5'd22: v = 26'd14;
        5'd23: v = 26'd7;
        default: v = '0;
      endcase
      return v;
    end
  endfunction

endpackage
`default_nettype wire

### design/ata_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ata_fifo: small register queue
// First-word-fall-through queue used between the front end and the pipeline.
// ----------------------------------------------------------------------------
module ata_fifo
  import ata_pkg::*;
#(
  parameter int WIDTH = 48,
  parameter int DEPTH = FIFO_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             rd_en,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wp_r, rp_r;
  logic [AW:0]      cnt_r;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en && !full) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en && !full) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd_en && !empty) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en && !full) - (AW+1)'(rd_en && !empty);
    end
  end
endmodule
`default_nettype wire

### design/ata_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ata_front: calibration front end
// Holds the calibration registers and corrects one sample, registered.
// ----------------------------------------------------------------------------
module ata_front
  import ata_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_take,
  input  wire logic        c_ready,
  input  wire in_item_t    in_item,
  output logic             c_valid,
  output corr_t            c_item
);
  logic signed [15:0] off_x_r, off_y_r, off_z_r;
  logic [14:0]        grav_r;
  logic               c_valid_r;
  corr_t              c_item_r, c_nxt;

  function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
    if (v > 18'sd32767) return 16'sh7fff;
    if (v < -18'sd32768) return 16'sh8000;
    return v[15:0];
  endfunction

  always_comb begin
    c_nxt.cx = sat16(18'(in_item.accel_x) - 18'(off_x_r));
    c_nxt.cy = sat16(18'(in_item.accel_y) - 18'(off_y_r));
    c_nxt.cz = sat16(18'(in_item.accel_z) - 18'(off_z_r)
                     + $signed({3'b0, grav_r}));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_x_r <= '0;
      off_y_r <= '0;
      off_z_r <= '0;
      grav_r  <= GRAVITY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_OFFSET_X: off_x_r <= cfg_data;
        REG_OFFSET_Y: off_y_r <= cfg_data;
        REG_OFFSET_Z: off_z_r <= cfg_data;
        REG_GRAVITY:  grav_r  <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // hold the corrected sample until the queue behind can take it
  always_ff @(posedge clk) begin
    if (!rst_n)       c_valid_r <= 1'b0;
    else if (in_take) c_valid_r <= 1'b1;
    else if (c_ready) c_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_take) c_item_r <= c_nxt;
  end

  assign c_valid = c_valid_r;
  assign c_item  = c_item_r;
endmodule
`default_nettype wire

### design/ata_angle.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ata_angle: pipelined tilt angle
// Square, normalise, pipelined square root, 24-stage vectoring CORDIC, round.
// Advances only when en is high.
// ----------------------------------------------------------------------------
module ata_angle
  import ata_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               en,
  input  wire logic signed [16:0] num,
  input  wire logic signed [15:0] da,
  input  wire logic signed [15:0] db,
  output logic signed [15:0]      angle
);
  localparam int SH = UNIT_BITS - ANGLE_FRAC_BITS;
  localparam int NS = SQRT_STEPS + 1;

  // stage A: squares
  logic signed [16:0] a_num_r;
  logic [31:0]        a_aa_r, a_bb_r, a_nn_r;
  always_ff @(posedge clk) begin
    if (en) begin
      a_num_r <= num;
      a_aa_r  <= 32'($signed(da) * $signed(da));
      a_bb_r  <= 32'($signed(db) * $signed(db));
      a_nn_r  <= 32'($signed(num) * $signed(num));
    end
  end

  // stage B: sum and normalising shift count (k such that max<<2k >= 2^58)
  logic signed [16:0] b_num_r;
  logic [32:0]        b_sq_r;
  logic [4:0]         b_k_r;
  logic [32:0]        sq_w, mx_w;
  logic [4:0]         k_w;
  always_comb begin
    sq_w = 33'(a_aa_r) + 33'(a_bb_r);
    mx_w = (33'(a_nn_r) > sq_w) ? 33'(a_nn_r) : sq_w;
    k_w  = 5'd29;
    for (int j = 32; j >= 0; j--) begin
      if (mx_w[j] && k_w == 5'd29) k_w = 5'((59 - j) / 2);
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      b_num_r <= a_num_r;
      b_sq_r  <= sq_w;
      b_k_r   <= k_w;
    end
  end

  // square root pipeline, one result bit per stage, 31 bits over 62-bit value
  logic [61:0]        s_rem_r [NS];
  logic [61:0]        s_v_r   [NS];
  logic [30:0]        s_root_r[NS];
  logic signed [46:0] s_y_r   [NS];
  logic               s_zero_r[NS];
  logic signed [16:0] s_num_r [NS];

  always_ff @(posedge clk) begin
    if (en) begin
      s_v_r[0]    <= 62'(b_sq_r) << (2 * b_k_r);
      s_rem_r[0]  <= '0;
      s_root_r[0] <= '0;
      s_y_r[0]    <= 47'(b_num_r) <<< b_k_r;
      s_zero_r[0] <= (b_sq_r == '0);
      s_num_r[0]  <= b_num_r;
    end
  end

  for (genvar s = 0; s < SQRT_STEPS; s++) begin : g_sqrt
    logic [63:0] rem_w, trial_w;
    always_comb begin
      rem_w   = {s_rem_r[s], s_v_r[s][61:60]};
      trial_w = {31'b0, s_root_r[s], 2'b01};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        s_v_r[s+1]    <= s_v_r[s] << 2;
        s_rem_r[s+1]  <= (rem_w >= trial_w) ? 62'(rem_w - trial_w) : 62'(rem_w);
        s_root_r[s+1] <= {s_root_r[s][29:0], rem_w >= trial_w};
        s_y_r[s+1]    <= s_y_r[s];
        s_zero_r[s+1] <= s_zero_r[s];
        s_num_r[s+1]  <= s_num_r[s];
      end
    end
  end

  // CORDIC vectoring stages
  localparam int CW = 48;
  logic signed [CW-1:0] c_x_r [CORDIC_STEPS+1];
  logic signed [CW-1:0] c_y_r [CORDIC_STEPS+1];
  logic signed [31:0]   c_z_r [CORDIC_STEPS+1];
  logic                 c_zero_r[CORDIC_STEPS+1];
  logic signed [16:0]   c_num_r [CORDIC_STEPS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      c_x_r[0]    <= CW'($signed({1'b0, s_root_r[SQRT_STEPS]}));
      c_y_r[0]    <= CW'(s_y_r[SQRT_STEPS]);
      c_z_r[0]    <= '0;
      c_zero_r[0] <= s_zero_r[SQRT_STEPS];
      c_num_r[0]  <= s_num_r[SQRT_STEPS];
    end
  end

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    logic signed [CW-1:0] dx_w, dy_w;
    logic signed [31:0]   at_w;
    always_comb begin
      dx_w = c_y_r[i] >>> i;
      dy_w = c_x_r[i] >>> i;
      at_w = 32'($signed({1'b0, atan_tab(5'(i))}));
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (c_y_r[i] > 0) begin
          c_x_r[i+1] <= c_x_r[i] + dx_w;
          c_y_r[i+1] <= c_y_r[i] - dy_w;
          c_z_r[i+1] <= c_z_r[i] + at_w;
        end else begin
          c_x_r[i+1] <= c_x_r[i] - dx_w;
          c_y_r[i+1] <= c_y_r[i] + dy_w;
          c_z_r[i+1] <= c_z_r[i] - at_w;
        end
        c_zero_r[i+1] <= c_zero_r[i];
        c_num_r[i+1]  <= c_num_r[i];
      end
    end
  end

  // final: special case, round to nearest, saturate
  logic signed [31:0] zf_w, rnd_w;
  logic signed [15:0] ang_r;
  always_comb begin
    if (c_zero_r[CORDIC_STEPS]) begin
      if (c_num_r[CORDIC_STEPS] > 0)      zf_w = 32'sd90 <<< UNIT_BITS;
      else if (c_num_r[CORDIC_STEPS] < 0) zf_w = -(32'sd90 <<< UNIT_BITS);
      else                                zf_w = '0;
    end else begin
      zf_w = c_z_r[CORDIC_STEPS];
    end
    rnd_w = (zf_w + (32'sd1 <<< (SH - 1))) >>> SH;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      if (rnd_w > 32'sd32767)       ang_r <= 16'sh7fff;
      else if (rnd_w < -32'sd32768) ang_r <= 16'sh8000;
      else                          ang_r <= rnd_w[15:0];
    end
  end
  assign angle = ang_r;
endmodule
`default_nettype wire

### design/accel_tilt_angles_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// accel_tilt_angles_unit: accelerometer tilt angles
// Calibrates a three-axis sample and gives roll and pitch in 2^-F degree.
// ----------------------------------------------------------------------------
// Path: front register, decoupling queue, angle pipeline, result queue.
// Throughput: one transaction per cycle, set by the fully pipelined square
// root (one bit a stage) and CORDIC (one rotation a stage). The angle pipeline
// holds as a whole while a finished result waits on a full result queue.
// Reset: synchronous, active low; clears queues and valid bits, offsets to 0,
// gravity count to 8192.
// ----------------------------------------------------------------------------
module accel_tilt_angles_unit
  import ata_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_idx,
  input  wire logic [15:0] cfg_data,
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    in_item,
  output logic             empty,
  input  wire logic        pop,
  output out_item_t        out_item
);
  // pipeline depth of the angle path, including its final rounding stage
  localparam int PD = 2 + 1 + SQRT_STEPS + 1 + CORDIC_STEPS + 1;

  logic  in_take, c_valid, c_ready;
  corr_t c_item;

  // front end: calibrate and register, hold while the queue is full
  ata_front u_front (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data,
    .in_take, .c_ready, .in_item, .c_valid, .c_item
  );

  // decoupling queue between front and back
  logic  q_full, q_empty, q_pop;
  corr_t q_item;
  ata_fifo #(.WIDTH($bits(corr_t)), .DEPTH(FIFO_DEPTH)) u_q (
    .clk, .rst_n, .wr_en(c_valid), .wr_data(c_item), .full(q_full),
    .rd_en(q_pop), .rd_data(q_item), .empty(q_empty)
  );

  // refuse input only while the front register is held by a full queue
  assign c_ready = !q_full;
  assign full    = c_valid && q_full;
  assign in_take = push && !full;

  // back end: angle pipeline advancing as one, valid tracked alongside
  logic o_full, o_empty, o_wr, en;
  logic [PD-1:0] vpipe_r;
  corr_t         cpipe_r [PD];

  // advance unless the last stage holds a result the result queue cannot take
  assign en    = !vpipe_r[PD-1] || !o_full;
  assign q_pop = !q_empty && en;

  always_ff @(posedge clk) begin
    if (!rst_n) vpipe_r <= '0;
    else if (en) vpipe_r <= {vpipe_r[PD-2:0], q_pop};
  end
  always_ff @(posedge clk) begin
    if (en) begin
      cpipe_r[0] <= q_item;
      for (int p = 1; p < PD; p++) cpipe_r[p] <= cpipe_r[p-1];
    end
  end

  logic signed [15:0] roll, pitch;
  ata_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_roll (
    .clk, .en(en), .num(17'(q_item.cy)), .da(q_item.cx), .db(q_item.cz),
    .angle(roll)
  );
  ata_angle #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_pitch (
    .clk, .en(en), .num(-17'(q_item.cx)), .da(q_item.cy), .db(q_item.cz),
    .angle(pitch)
  );

  // result queue
  out_item_t o_in;
  assign o_wr = vpipe_r[PD-1] && !o_full;
  always_comb begin
    o_in.corr_x      = cpipe_r[PD-1].cx;
    o_in.corr_y      = cpipe_r[PD-1].cy;
    o_in.corr_z      = cpipe_r[PD-1].cz;
    o_in.roll_angle  = roll;
    o_in.pitch_angle = pitch;
  end
  ata_fifo #(.WIDTH($bits(out_item_t)), .DEPTH(FIFO_DEPTH)) u_oq (
    .clk, .rst_n, .wr_en(o_wr), .wr_data(o_in), .full(o_full),
    .rd_en(pop), .rd_data(out_item), .empty(o_empty)
  );
  assign empty = o_empty;
endmodule
`default_nettype wire
